### hw/rtl/lfu_pkg.sv
package lfu_pkg;

  // Geometry
  localparam int ENTRIES      = 64;
  localparam int ADDRESS_BITS = 12;
  localparam int OFFSET_BITS  = 5;
  localparam int COUNT_BITS   = 16;

  localparam int TAG_BITS  = ADDRESS_BITS - OFFSET_BITS;
  localparam int IDX_BITS  = $clog2(ENTRIES);
  localparam int FILL_BITS = $clog2(ENTRIES + 1);

  localparam logic [ADDRESS_BITS-1:0] LIMIT_RESET = ADDRESS_BITS'(3072);
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0]  OFF_ONES    = {OFFSET_BITS{1'b1}};

  // Register file: one 32-bit register, word index in paddr[2]
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam logic REG_ADDRESS_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic                    accepted;
    logic                    hit;
    logic [IDX_BITS-1:0]     block_index;
    logic [COUNT_BITS-1:0]   block_hits;
    logic [ADDRESS_BITS-1:0] range_low;
    logic [ADDRESS_BITS-1:0] range_high;
  } res_t;

endpackage

### hw/rtl/lfu_if.sv
// Request channel: one address word
interface lfu_req_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ADDRESS_BITS-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

// Response channel: one lookup result word
interface lfu_rsp_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic                    hit;
  logic [IDX_BITS-1:0]     block_index;
  logic [COUNT_BITS-1:0]   block_hits;
  logic [ADDRESS_BITS-1:0] range_low;
  logic [ADDRESS_BITS-1:0] range_high;

  modport source (output valid, output accepted, output hit, output block_index,
                  output block_hits, output range_low, output range_high,
                  input ready);
  modport sink   (input valid, input accepted, input hit, input block_index,
                  input block_hits, input range_low, input range_high,
                  output ready);
endinterface

### hw/rtl/lfu_fully_associative_cache_tags_unit.sv
// Channel  Dir  Words carried                                     Handshake
// req      in   address                                           valid/ready
// rsp      out  accepted, hit, block_index, block_hits,           valid/ready
//               range_low, range_high
// apb      in   address_limit at byte 0                           psel/penable
//
// An accepted address passes through SCAN, DRAIN and UPDATE to the result
// register: the tag and count memories are swept one entry a cycle
// through their single read port. A rejected address goes straight to HOLD.
// One address is in flight at a time; req.ready is high only when idle, so
// a new address is taken only after the last one has left HOLD.
// A finished lookup waits in HOLD, with req.ready low, while the result
// register is full and rsp.ready is low.
// Reset (rst, synchronous) empties the store: the fill count alone marks
// valid entries, so no clearing pass over the memories is needed.
module lfu_fully_associative_cache_tags_unit (
  input  logic                           clk,
  input  logic                           rst,
  lfu_req_if.sink                        req,
  lfu_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lfu_pkg::PADDR_BITS-1:0] paddr,
  input  logic [lfu_pkg::PDATA_BITS-1:0] pwdata,
  output logic [lfu_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready
);
  import lfu_pkg::*;

  state_t state, state_next;

  logic [ADDRESS_BITS-1:0] address_limit;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [FILL_BITS-1:0]    fill_count;

  // Memories and their read ports
  logic [TAG_BITS-1:0]   tag_mem [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
  logic [TAG_BITS-1:0]   rd_tag;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [IDX_BITS-1:0]   rd_idx;
  logic                  cmp_valid;
  logic [IDX_BITS-1:0]   cmp_idx;

  // Sweep results
  logic                  found;
  logic [IDX_BITS-1:0]   found_idx;
  logic [COUNT_BITS-1:0] found_cnt;
  logic [IDX_BITS-1:0]   victim_idx;
  logic [COUNT_BITS-1:0] victim_cnt;

  logic                  wr_en;
  logic                  wr_tag_en;
  logic [IDX_BITS-1:0]   wr_idx;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic                  full;

  res_t res, out_q;
  logic out_valid;

  logic req_fire, cfg_write, reject, out_free;
  logic [TAG_BITS-1:0] tag;
  logic entry_live, tag_match;

  assign req_fire  = req.valid && req.ready;
  assign reject    = req.address > address_limit;
  assign tag       = addr_q[ADDRESS_BITS-1:OFFSET_BITS];
  assign full      = fill_count == FILL_BITS'(ENTRIES);
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = state == ST_IDLE;

  // Config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_ADDRESS_LIMIT) ? PDATA_BITS'(address_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_limit <= LIMIT_RESET;
    end else if (cfg_write && paddr[2] == REG_ADDRESS_LIMIT) begin
      address_limit <= pwdata[ADDRESS_BITS-1:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) state_next = reject ? ST_HOLD : ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_idx == IDX_BITS'(ENTRIES - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_HOLD;
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory read and write; sweep reads never overlap the single write
  always_ff @(posedge clk) begin
    rd_tag <= tag_mem[rd_idx];
    rd_cnt <= cnt_mem[rd_idx];
    if (wr_en) begin
      cnt_mem[wr_idx] <= wr_cnt;
      if (wr_tag_en) tag_mem[wr_idx] <= tag;
    end
  end

  // Sweep address and compare stage tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= state == ST_SCAN;
      if (state == ST_SCAN) begin
        rd_idx <= rd_idx + 1'b1;
      end else begin
        rd_idx <= '0;
      end
    end
    cmp_idx <= rd_idx;
  end

  // Compare one entry: first live match, and least count (lowest index wins)
  assign entry_live = FILL_BITS'(cmp_idx) < fill_count;
  assign tag_match  = entry_live && rd_tag == tag;

  always_ff @(posedge clk) begin
    if (req_fire) begin
      addr_q <= req.address;
      found  <= 1'b0;
    end else if (cmp_valid) begin
      if (tag_match && !found) begin
        found     <= 1'b1;
        found_idx <= cmp_idx;
        found_cnt <= rd_cnt;
      end
      if (cmp_idx == '0 || rd_cnt < victim_cnt) begin
        victim_idx <= cmp_idx;
        victim_cnt <= rd_cnt;
      end
    end
  end

  // Update: choose entry and new count
  always_comb begin
    wr_en     = state == ST_UPDATE;
    wr_tag_en = !found;
    if (found) begin
      wr_idx = found_idx;
      wr_cnt = (found_cnt == COUNT_MAX) ? found_cnt : found_cnt + 1'b1;
    end else if (!full) begin
      wr_idx = fill_count[IDX_BITS-1:0];
      wr_cnt = '0;
    end else begin
      wr_idx = victim_idx;
      wr_cnt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (state == ST_UPDATE && !found && !full) begin
      fill_count <= fill_count + 1'b1;
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_fire && reject) begin
      res <= '0;
    end else if (state == ST_UPDATE) begin
      res.accepted    <= 1'b1;
      res.hit         <= found;
      res.block_index <= wr_idx;
      res.block_hits  <= wr_cnt;
      res.range_low   <= {tag, {OFFSET_BITS{1'b0}}};
      res.range_high  <= {tag, OFF_ONES};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_HOLD && out_free) out_q <= res;
  end

  assign rsp.valid       = out_valid;
  assign rsp.accepted    = out_q.accepted;
  assign rsp.hit         = out_q.hit;
  assign rsp.block_index = out_q.block_index;
  assign rsp.block_hits  = out_q.block_hits;
  assign rsp.range_low   = out_q.range_low;
  assign rsp.range_high  = out_q.range_high;

endmodule

### hw/rtl/lfu_chk.sv
module lfu_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic                               accepted,
  input logic                               hit,
  input logic [lfu_pkg::IDX_BITS-1:0]       block_index,
  input logic [lfu_pkg::COUNT_BITS-1:0]     block_hits,
  input logic [lfu_pkg::ADDRESS_BITS-1:0]   range_low,
  input logic [lfu_pkg::ADDRESS_BITS-1:0]   range_high
);
  import lfu_pkg::*;

  // Stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(block_hits) && $stable(range_low))
    else $error("result changed while stalled");

  // One lookup at a time: a taken address closes the request side
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken during a lookup");

  // Rejected words are all zero
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !accepted |-> !hit && block_index == '0 && block_hits == '0 &&
      range_low == '0 && range_high == '0)
    else $error("rejected word not cleared");

  // Accepted words cover one aligned block
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && accepted |-> range_low[OFFSET_BITS-1:0] == '0 &&
      range_high == (range_low | ADDRESS_BITS'(OFF_ONES)))
    else $error("bad block range");

  // A fill starts at zero, a hit never reports zero
  a_hits: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && accepted |-> (hit && block_hits != '0) || (!hit && block_hits == '0))
    else $error("hit count inconsistent with hit flag");

endmodule

bind lfu_fully_associative_cache_tags_unit lfu_chk u_lfu_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .accepted    (rsp.accepted),
  .hit         (rsp.hit),
  .block_index (rsp.block_index),
  .block_hits  (rsp.block_hits),
  .range_low   (rsp.range_low),
  .range_high  (rsp.range_high)
);

### tb/lfu_fully_associative_cache_tags_unit_tb.sv
module lfu_fully_associative_cache_tags_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_pkg::*;

  // Second register word, not decoded by the block
  localparam logic REG_SPARE    = 1'b1;
  localparam int   SWEEP_CYCLES = ENTRIES + 8;
  localparam int   LIMIT_CYCLES = 600_000;
  localparam int   HOT_MAX      = 24;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  lfu_req_if req ();
  lfu_rsp_if rsp ();

  lfu_fully_associative_cache_tags_unit dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the tag store; fill_n entries are valid
  logic [ADDRESS_BITS-1:0] limit_q;
  logic [TAG_BITS-1:0]     tag_mem   [ENTRIES];
  logic [COUNT_BITS-1:0]   count_mem [ENTRIES];
  int                      fill_n;
  res_t                    lookups_due [$];

  int                      errors = 0;
  int                      cycles = 0;
  bit                      quiet = 1'b0;
  int                      holdoff_cycles = 0;
  logic [TAG_BITS-1:0]     hot_blocks [HOT_MAX];
  int                      hot_n = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Lookup of one address against the shadow store, updating it
  function automatic res_t lookup_block(input logic [ADDRESS_BITS-1:0] addr);
    res_t                r;
    logic [TAG_BITS-1:0] tag;
    int                  idx;
    bit                  found;
    r     = '0;
    idx   = 0;
    found = 1'b0;
    if (addr > limit_q) return r;
    tag = addr[ADDRESS_BITS-1:OFFSET_BITS];
    for (int k = 0; k < fill_n; k++) begin
      if (!found && tag_mem[k] == tag) begin
        idx   = k;
        found = 1'b1;
      end
    end
    if (found) begin
      if (count_mem[idx] != COUNT_MAX) count_mem[idx] = count_mem[idx] + 1'b1;
    end else begin
      if (fill_n < ENTRIES) begin
        idx = fill_n;
        fill_n++;
      end else begin
        // least used entry, lowest index wins a tie
        for (int k = 1; k < ENTRIES; k++)
          if (count_mem[k] < count_mem[idx]) idx = k;
      end
      tag_mem[idx]   = tag;
      count_mem[idx] = '0;
    end
    r.accepted    = 1'b1;
    r.hit         = found;
    r.block_index = idx[IDX_BITS-1:0];
    r.block_hits  = count_mem[idx];
    r.range_low   = {tag, {OFFSET_BITS{1'b0}}};
    r.range_high  = {tag, OFF_ONES};
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  function automatic void compare_lookup();
    res_t e;
    if (lookups_due.size() == 0) begin
      $display("%0t: result word with none expected: expected nothing, got idx %0d",
               $time, rsp.block_index);
      errors++;
      return;
    end
    e = lookups_due.pop_front();
    check_field("accepted", 32'(e.accepted), 32'(rsp.accepted));
    check_field("hit", 32'(e.hit), 32'(rsp.hit));
    check_field("block_index", 32'(e.block_index), 32'(rsp.block_index));
    check_field("block_hits", 32'(e.block_hits), 32'(rsp.block_hits));
    check_field("range_low", 32'(e.range_low), 32'(rsp.range_low));
    check_field("range_high", 32'(e.range_high), 32'(rsp.range_high));
  endfunction

  // Results are checked before the new request is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) compare_lookup();
      if (req.valid && req.ready)
        lookups_due.insert(lookups_due.size(), lookup_block(req.address));
    end
  end

  function automatic int draw_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int n;
    rsp.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      n = holdoff_cycles + draw_gap();
      holdoff_cycles = 0;
      if (n != 0) begin
        rsp.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready));
      @(negedge clk);
    end
  end

  // Offer one address word; returns just after the falling edge
  task automatic send_address(input logic [ADDRESS_BITS-1:0] addr);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.address <= addr;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  // Let every lookup finish and the sweep settle
  task automatic drain();
    req.valid <= 1'b0;
    wait (lookups_due.size() == 0);
    repeat (SWEEP_CYCLES) @(negedge clk);
  endtask

  // Write a register while idle, then read back the limit
  task automatic write_register(input logic idx, input logic [PDATA_BITS-1:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_ADDRESS_LIMIT) limit_q = val[ADDRESS_BITS-1:0];
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {REG_ADDRESS_LIMIT, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[ADDRESS_BITS-1:0] !== limit_q) begin
      $display("%0t: address_limit readback mismatch: expected %0d, got %0d",
               $time, limit_q, prdata[ADDRESS_BITS-1:0]);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [ADDRESS_BITS-1:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && hot_n > 0)
      return {hot_blocks[$urandom_range(0, hot_n - 1)], OFFSET_BITS'($urandom)};
    if (r < 85) return ADDRESS_BITS'($urandom_range(0, limit_q));
    return ADDRESS_BITS'($urandom);
  endfunction

  // One traffic phase: mostly a working set of blocks, some spread, some out of range
  task automatic run_phase(input logic [PDATA_BITS-1:0] lim, input int count,
                           input int hot, input int quiet_len);
    write_register(REG_ADDRESS_LIMIT, lim);
    for (int i = 0; i < hot; i++)
      hot_blocks[i] = TAG_BITS'($urandom_range(0, limit_q) >> OFFSET_BITS);
    hot_n = hot;
    for (int i = 0; i < count; i++) begin
      quiet = (i < quiet_len);
      send_address(pick_address());
    end
    quiet = 1'b0;
  endtask

  // Reset limit: boundary addresses, hits within a block, alternating bits
  task automatic test_limit_edges();
    send_address(12'd0);
    send_address(12'd0);
    send_address(12'd31);
    send_address(12'd32);
    send_address(12'd3072);
    send_address(12'd3073);
    send_address(12'd4095);
    send_address(12'hAAA);
    send_address(12'h555);
    send_address(12'd3071);
    send_address(12'd3072);
  endtask

  // Limit at zero, ignored write to the spare word, upper data bits masked
  task automatic test_register_access();
    write_register(REG_ADDRESS_LIMIT, 32'd0);
    send_address(12'd0);
    send_address(12'd1);
    send_address(12'd4095);
    write_register(REG_SPARE, 32'd4095);
    send_address(12'd1);
    send_address(12'd0);
    write_register(REG_ADDRESS_LIMIT, 32'hFFFF_F010);
    send_address(12'd16);
    send_address(12'd17);
    write_register(REG_ADDRESS_LIMIT, 32'd4095);
    send_address(12'd4095);
    send_address(12'd4064);
  endtask

  task automatic test_random_traffic();
    run_phase(32'd4095, 500, 16, 100);
    run_phase(32'(LIMIT_RESET), 400, 24, 0);
    run_phase($urandom_range(32, 4094), 300, 12, 50);
    run_phase(32'd31, 40, 1, 0);
    run_phase(32'd0, 25, 1, 0);
    run_phase(32'd4095, 400, 6, 0);
  endtask

  // Result side holds off while addresses keep coming
  task automatic test_output_stall();
    holdoff_cycles = 400;
    quiet = 1'b1;
    for (int i = 0; i < 8; i++) send_address(pick_address());
    quiet = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    req.valid   = 1'b0;
    req.address = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    limit_q     = LIMIT_RESET;
    fill_n      = 0;
    for (int k = 0; k < ENTRIES; k++) begin
      tag_mem[k]   = '0;
      count_mem[k] = '0;
    end
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_limit_edges();
    test_register_access();
    test_random_traffic();
    test_output_stall();
    drain();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
